### sv/mma_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the matrix multiply-accumulate block.
// No dependencies.
package mma_pkg;

    localparam int IDX_FIELD_W = 3;
    localparam int DIM_W       = 4;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] REG_INNER_COUNT  = 2'd1;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD_LEFT  = 2'd0,
        OP_LOAD_RIGHT = 2'd1,
        OP_COMPUTE    = 2'd2
    } t_op;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_RUN  = 1'b1
    } t_seq_state;

    typedef struct packed {
        logic [DIM_W-1:0] row_count;
        logic [DIM_W-1:0] inner_count;
        logic [DIM_W-1:0] column_count;
    } t_dims;

    // Tag that travels with each multiply through the pipeline.
    typedef struct packed {
        logic                   valid;
        logic                   first;
        logic                   lastk;
        logic [IDX_FIELD_W-1:0] row;
        logic [IDX_FIELD_W-1:0] col;
        logic                   last;
    } t_tag;

endpackage

### sv/mma_in_if.sv
`timescale 1ns / 1ps
// Request channel: load and compute requests.
// Depends on mma_pkg.
interface mma_in_if
    import mma_pkg::*;
#(
    parameter int ELEM_BITS = 16
);
    logic                        valid;
    logic                        ready;
    logic [1:0]                  op;
    logic [IDX_FIELD_W-1:0]      row_index;
    logic [IDX_FIELD_W-1:0]      col_index;
    logic signed [ELEM_BITS-1:0] element_value;

    modport source (output valid, op, row_index, col_index, element_value, input ready);
    modport sink   (input valid, op, row_index, col_index, element_value, output ready);
endinterface

### sv/mma_out_if.sv
`timescale 1ns / 1ps
// Result channel: one output element per dot product of a compute request.
// Depends on mma_pkg.
interface mma_out_if
    import mma_pkg::*;
#(
    parameter int SUM_BITS = 35
);
    logic                       valid;
    logic                       ready;
    logic [IDX_FIELD_W-1:0]     out_row;
    logic [IDX_FIELD_W-1:0]     out_column;
    logic signed [SUM_BITS-1:0] dot_sum;
    logic                       last;

    modport source (output valid, out_row, out_column, dot_sum, last, input ready);
    modport sink   (input valid, out_row, out_column, dot_sum, last, output ready);
endinterface

### sv/matrix_multiply_accumulate.sv
`timescale 1ns / 1ps
// Matrix multiply-accumulate top level: Q8.8 operands, exact Q.16 dot products.
// Depends on mma_pkg, mma_in_if, mma_out_if, mma_ram, mma_cfg, mma_seq, mma_mac.
//
// Usage:
//   i_req carries load-left, load-right and compute requests (valid/ready).
//   A load writes one element at row*MAX_DIM+col of the left or right store
//   and produces nothing. Indexes at or beyond MAX_DIM are dropped. A
//   compute streams rows*columns results on o_rsp in row-major order, last
//   marking the final one.
//   Throughput: one multiply-accumulate per cycle while o_rsp does not
//   stall, so a compute holds i_req off while its multiplies are issued.
//   The dimension registers (APB, 0x0 rows, 0x4 inner, 0x8 columns) reset
//   to 8; the sequencer uses zero as 1 and anything above MAX_DIM as MAX_DIM.
//   Store contents are undefined after reset until loaded.
//   When o_rsp stalls, the whole multiply pipeline freezes and resumes
//   without loss; a new request is taken once all reads are issued.
module matrix_multiply_accumulate
    import mma_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mma_in_if.sink                i_req,
    mma_out_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SUM_BITS = 2 * ELEM_BITS + $clog2(MAX_DIM);
    localparam logic [IDX_FIELD_W:0] MAX_IDX = (IDX_FIELD_W+1)'(MAX_DIM);
    localparam logic [ADDR_W-1:0]    STRIDE  = ADDR_W'(MAX_DIM);

    t_dims                dims;
    t_tag                 tag;
    logic                 accept, busy, en, in_range;
    logic                 we_left, we_right, start;
    logic [ADDR_W-1:0]    waddr, left_addr, right_addr;
    logic [ELEM_BITS-1:0] left_data, right_data;

    assign i_req.ready = !busy;
    assign accept      = i_req.valid && !busy;
    assign in_range    = ({1'b0, i_req.row_index} < MAX_IDX) &&
                         ({1'b0, i_req.col_index} < MAX_IDX);
    assign waddr       = ADDR_W'(i_req.row_index) * STRIDE + ADDR_W'(i_req.col_index);
    assign we_left     = accept && in_range && (i_req.op == OP_LOAD_LEFT);
    assign we_right    = accept && in_range && (i_req.op == OP_LOAD_RIGHT);
    assign start       = accept && (i_req.op == OP_COMPUTE);

    mma_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_dims  (dims)
    );

    mma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_left (
        .i_clk   (i_clk),
        .i_we    (we_left),
        .i_waddr (waddr),
        .i_wdata (i_req.element_value),
        .i_re    (en),
        .i_raddr (left_addr),
        .o_rdata (left_data)
    );

    mma_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_right (
        .i_clk   (i_clk),
        .i_we    (we_right),
        .i_waddr (waddr),
        .i_wdata (i_req.element_value),
        .i_re    (en),
        .i_raddr (right_addr),
        .o_rdata (right_data)
    );

    mma_seq #(.MAX_DIM(MAX_DIM)) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_en         (en),
        .i_dims       (dims),
        .o_left_addr  (left_addr),
        .o_right_addr (right_addr),
        .o_tag        (tag),
        .o_busy       (busy)
    );

    mma_mac #(.ELEM_BITS(ELEM_BITS), .SUM_BITS(SUM_BITS)) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag),
        .i_left   (left_data),
        .i_right  (right_data),
        .o_en     (en),
        .o_valid  (o_rsp.valid),
        .i_ready  (o_rsp.ready),
        .o_row    (o_rsp.out_row),
        .o_column (o_rsp.out_column),
        .o_sum    (o_rsp.dot_sum),
        .o_last   (o_rsp.last)
    );
endmodule

### sv/mma_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mma_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

### sv/mma_cfg.sv
`timescale 1ns / 1ps
// APB register bank for the matrix dimensions.
// Depends on mma_pkg.
module mma_cfg
    import mma_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_dims                 o_dims
);
    t_dims      r_dims;
    logic       wr;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[3:2];
    assign o_dims = r_dims;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims.row_count    <= DIM_RESET;
            r_dims.inner_count  <= DIM_RESET;
            r_dims.column_count <= DIM_RESET;
        end else if (wr) begin
            unique case (idx)
                REG_ROW_COUNT:    r_dims.row_count    <= pwdata[DIM_W-1:0];
                REG_INNER_COUNT:  r_dims.inner_count  <= pwdata[DIM_W-1:0];
                REG_COLUMN_COUNT: r_dims.column_count <= pwdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ROW_COUNT:    prdata = APB_DATA_W'(r_dims.row_count);
            REG_INNER_COUNT:  prdata = APB_DATA_W'(r_dims.inner_count);
            REG_COLUMN_COUNT: prdata = APB_DATA_W'(r_dims.column_count);
            default:          prdata = '0;
        endcase
    end
endmodule

### sv/mma_seq.sv
`timescale 1ns / 1ps
// Compute sequencer: walks row, column and inner index, issues store reads.
// Depends on mma_pkg.
module mma_seq
    import mma_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_en,
    input  t_dims                                i_dims,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_left_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   o_right_addr,
    output t_tag                                 o_tag,
    output logic                                 o_busy
);
    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
    localparam logic [DIM_W-1:0]  MAX_D = DIM_W'(MAX_DIM);
    localparam logic [ADDR_W-1:0] STRIDE = ADDR_W'(MAX_DIM);

    function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] m;
        begin
            if (d == '0) begin
                m = '0;
            end else if (d > MAX_D) begin
                m = MAX_D - DIM_W'(1);
            end else begin
                m = d - DIM_W'(1);
            end
            return m[IDX_W-1:0];
        end
    endfunction

    t_seq_state       r_state, n_state;
    logic [IDX_W-1:0] r_i, r_j, r_k, n_i, n_j, n_k;
    logic [IDX_W-1:0] il, jl, kl;
    logic             issue, k_end, j_end, i_end;
    t_tag             r_tag, n_tag;

    assign il    = last_idx(i_dims.row_count);
    assign kl    = last_idx(i_dims.inner_count);
    assign jl    = last_idx(i_dims.column_count);
    assign k_end = (r_k == kl);
    assign j_end = (r_j == jl);
    assign i_end = (r_i == il);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_RUN;
            S_RUN:  if (i_en && k_end && j_end && i_end) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        issue  = 1'b0;
        o_busy = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_RUN: begin
                issue  = 1'b1;
                o_busy = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        if (i_start && !issue) begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
        end else if (issue && i_en) begin
            if (!k_end) begin
                n_k = r_k + IDX_W'(1);
            end else begin
                n_k = '0;
                if (!j_end) begin
                    n_j = r_j + IDX_W'(1);
                end else begin
                    n_j = '0;
                    n_i = r_i + IDX_W'(1);
                end
            end
        end
    end

    always_comb begin
        n_tag.valid = issue;
        n_tag.first = (r_k == '0);
        n_tag.lastk = k_end;
        n_tag.row   = IDX_FIELD_W'(r_i);
        n_tag.col   = IDX_FIELD_W'(r_j);
        n_tag.last  = i_end && j_end;
    end

    assign o_left_addr  = ADDR_W'(r_i) * STRIDE + ADDR_W'(r_k);
    assign o_right_addr = ADDR_W'(r_k) * STRIDE + ADDR_W'(r_j);
    assign o_tag        = r_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_tag.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            if (i_en) begin
                r_tag.valid <= n_tag.valid;
            end
        end
        if (i_en) begin
            r_tag.first <= n_tag.first;
            r_tag.lastk <= n_tag.lastk;
            r_tag.row   <= n_tag.row;
            r_tag.col   <= n_tag.col;
            r_tag.last  <= n_tag.last;
        end
    end
endmodule

### sv/mma_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate pipeline with result register and stall control.
// Depends on mma_pkg.
module mma_mac
    import mma_pkg::*;
#(
    parameter int ELEM_BITS = 16,
    parameter int SUM_BITS  = 35
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_tag                       i_tag,
    input  logic [ELEM_BITS-1:0]       i_left,
    input  logic [ELEM_BITS-1:0]       i_right,
    output logic                       o_en,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [IDX_FIELD_W-1:0]     o_row,
    output logic [IDX_FIELD_W-1:0]     o_column,
    output logic signed [SUM_BITS-1:0] o_sum,
    output logic                       o_last
);
    localparam int PROD_W = 2 * ELEM_BITS;

    t_tag                       r_s2, r_s3;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SUM_BITS-1:0] r_acc;
    logic signed [SUM_BITS-1:0] prod_ext;
    logic                       done, push;

    assign done     = r_s3.valid && r_s3.lastk;
    assign o_en     = !(done && o_valid && !i_ready);
    assign push     = done && o_en;
    assign prod_ext = {{(SUM_BITS-PROD_W){r_prod[PROD_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
            o_valid    <= 1'b0;
        end else begin
            if (o_en) begin
                r_s2.valid <= i_tag.valid;
                r_s3.valid <= r_s2.valid;
            end
            if (push) begin
                o_valid <= 1'b1;
            end else if (i_ready) begin
                o_valid <= 1'b0;
            end
        end
        if (o_en) begin
            r_prod      <= $signed(i_left) * $signed(i_right);
            r_s2.first  <= i_tag.first;
            r_s2.lastk  <= i_tag.lastk;
            r_s2.row    <= i_tag.row;
            r_s2.col    <= i_tag.col;
            r_s2.last   <= i_tag.last;
            r_acc       <= r_s2.first ? prod_ext : r_acc + prod_ext;
            r_s3.first  <= r_s2.first;
            r_s3.lastk  <= r_s2.lastk;
            r_s3.row    <= r_s2.row;
            r_s3.col    <= r_s2.col;
            r_s3.last   <= r_s2.last;
        end
        if (push) begin
            o_row    <= r_s3.row;
            o_column <= r_s3.col;
            o_sum    <= r_acc;
            o_last   <= r_s3.last;
        end
    end
endmodule
